FILE: rtl/sfr_pkg.sv
// sfr_pkg: shared types and constants for the sync/xor frame receiver
// used by sfr_deframer, sfr_out_stage and sync_xor_frame_receiver
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PAYLOAD_W = 64;

  localparam logic [BYTE_W-1:0] CHECK_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CHECK_OK   = 8'h00;

  // frame hunt / collect phases, one-hot
  typedef enum logic [3:0] {
    PH_HUNT0 = 4'b0001,
    PH_HUNT1 = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_CHECK = 4'b1000
  } phase_t;

  // one finished frame, handed from the deframer to the output stage
  typedef struct packed {
    logic                 fire;
    logic                 frame_valid;
    logic [PAYLOAD_W-1:0] frame_payload;
  } result_t;

endpackage

FILE: rtl/sfr_deframer.sv
// sfr_deframer: sync hunt, payload capture and xor check, one word per cycle while byte_en is high
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_deframer import sfr_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_en,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] sync_byte,
  output result_t           res
);

  localparam int unsigned CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PAYLOAD_BYTES - 1);

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] check_r, check_nxt;
  logic [BYTE_W-1:0] store_r [PAYLOAD_BYTES];
  logic              store_we;
  logic [BYTE_W-1:0] check_x;
  logic              is_sync;

  assign check_x = check_r ^ rx_byte;
  assign is_sync = (rx_byte == sync_byte);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    check_nxt = check_r;
    store_we  = 1'b0;
    res.fire  = 1'b0;
    // result fields: check byte closes the xor, payload packed low byte first
    res.frame_valid   = (check_x == CHECK_OK);
    res.frame_payload = '0;
    for (int i = 0; i < int'(PAYLOAD_BYTES); i++) begin
      res.frame_payload[BYTE_W*i +: BYTE_W] = store_r[i];
    end
    if (byte_en) begin
      unique case (phase_r)
        PH_HUNT0: begin
          phase_nxt = is_sync ? PH_HUNT1 : PH_HUNT0;
        end
        PH_HUNT1: begin
          if (is_sync) begin
            phase_nxt = PH_DATA;
            count_nxt = '0;
            check_nxt = CHECK_INIT;
          end else begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_DATA: begin
          store_we  = 1'b1;
          check_nxt = check_x;
          count_nxt = count_r + 1'b1;
          if (count_r == LAST_IDX) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res.fire  = 1'b1;
          phase_nxt = PH_HUNT0;
          count_nxt = '0;
          check_nxt = CHECK_INIT;
        end
        default: begin
          phase_nxt = PH_HUNT0;
          count_nxt = '0;
          check_nxt = CHECK_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT0;
      count_r <= '0;
      check_r <= CHECK_INIT;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      check_r <= check_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[count_r] <= rx_byte;
    end
  end

endmodule

FILE: rtl/sfr_out_stage.sv
// sfr_out_stage: result register between deframer and the out_ channel
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_out_stage import sfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  result_t              res,
  output logic                 take_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_frame_valid,
  output logic [PAYLOAD_W-1:0] out_frame_payload
);

  logic                 valid_r, valid_nxt;
  logic                 fv_r;
  logic [PAYLOAD_W-1:0] payload_r;

  // new word may enter when the register is empty or drains this cycle
  assign take_ok = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.fire) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fire) begin
      fv_r      <= res.frame_valid;
      payload_r <= res.frame_payload;
    end
  end

  assign out_valid         = valid_r;
  assign out_frame_valid   = fv_r;
  assign out_frame_payload = payload_r;

endmodule

FILE: rtl/sync_xor_frame_receiver.sv
// sync_xor_frame_receiver: top level of the sync/xor byte frame receiver
// depends on sfr_pkg, sfr_deframer and sfr_out_stage
`timescale 1ns / 1ps

// usage
//   in_ channel: one received byte per word (in_rx_byte), valid/ready
//   cfg_ channel: sync byte value, always ready, takes effect on the next word
//   out_ channel: one word per frame, out_frame_valid and out_frame_payload
//   a frame is two sync bytes, PAYLOAD_BYTES payload bytes, one check byte;
//   the check is 0xFF xor payload xor check byte, good when zero
// throughput and output
//   one input word per cycle while in_ready is high; the result appears on out_ in
//   the cycle after the check byte is accepted, held in the single result register
// reset
//   synchronous, active low; back to hunting, sync byte zero, out_ empty
// stall
//   while out_ holds a word that is not taken, in_ready stays low; it
//   rises in the same cycle that out_ready takes the pending word

module sync_xor_frame_receiver import sfr_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [BYTE_W-1:0]    cfg_sync_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_frame_valid,
  output logic [PAYLOAD_W-1:0] out_frame_payload
);

  logic [BYTE_W-1:0] sync_byte_r;
  logic              take_ok;
  logic              byte_en;
  result_t           res;

  // config register, written any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      sync_byte_r <= cfg_sync_byte;
    end
  end

  // accept a byte whenever the result register can take a word
  assign in_ready = take_ok;
  assign byte_en  = in_valid && in_ready;

  sfr_deframer #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .rx_byte   (in_rx_byte),
    .sync_byte (sync_byte_r),
    .res       (res)
  );

  sfr_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .res               (res),
    .take_ok           (take_ok),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_valid   (out_frame_valid),
    .out_frame_payload (out_frame_payload)
  );

  // a frame result only comes out of an accepted byte
  a_fire_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res.fire |-> (in_valid && in_ready))
    else $error("frame result without an accepted byte");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a finished frame shows up on out_ with its check flag next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res.fire |=> (out_valid && (out_frame_valid == $past(res.frame_valid))))
    else $error("frame result lost or corrupted");

  // a pending word that is not taken blocks new bytes
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while result stalled");

endmodule

FILE: sim/sync_xor_frame_receiver_tb.sv
// sync_xor_frame_receiver_tb: self-checking bench for the sync/xor byte frame receiver
// depends on sfr_pkg and sync_xor_frame_receiver; predicts every frame word in-bench
`timescale 1ns / 1ps

module sync_xor_frame_receiver_tb import sfr_pkg::*; ();

  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned MAX_GAP       = 13;
  // result register holds a single word; the settle wait after draining covers it
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned LONG_HOLD     = 150;
  localparam int unsigned PHASE_WORDS   = 220;

  // one expected frame word on the out_ channel
  typedef struct packed {
    logic                 frame_valid;
    logic [PAYLOAD_W-1:0] frame_payload;
  } frame_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [BYTE_W-1:0]    cfg_sync_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_frame_valid;
  logic [PAYLOAD_W-1:0] out_frame_payload;

  // predicted deframer state, mirrors the block word by word
  phase_t            hunt_phase;
  logic [3:0]        payload_count;
  logic [BYTE_W-1:0] xor_check;
  logic [BYTE_W-1:0] payload_bytes [8];
  logic [BYTE_W-1:0] sync_value;

  frame_word_t expected_frames [$];

  // knobs shared between the stimulus and the receiver process
  bit          tx_idle;
  bit          rx_idle;
  int unsigned hold_len;

  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned frames_checked;
  int unsigned good_frames;
  int unsigned cfg_writes;
  int unsigned quiet_cycles = 0;

  sync_xor_frame_receiver #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_sync_byte    (cfg_sync_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_valid  (out_frame_valid),
    .out_frame_payload(out_frame_payload)
  );

  always #6 clk = ~clk;

  // advance the predicted deframer by one received byte; a check byte
  // queues the frame word the block must produce
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    frame_word_t w;
    int          i;
    case (hunt_phase)
      PH_HUNT0: begin
        if (b == sync_value) hunt_phase = PH_HUNT1;
      end
      PH_HUNT1: begin
        // second sync in a row opens the frame, anything else restarts the hunt
        if (b == sync_value) begin
          hunt_phase    = PH_DATA;
          payload_count = '0;
          xor_check     = CHECK_INIT;
        end else begin
          hunt_phase = PH_HUNT0;
        end
      end
      PH_DATA: begin
        // sync values in here are plain payload
        payload_bytes[payload_count[2:0]] = b;
        xor_check     = xor_check ^ b;
        payload_count = payload_count + 4'd1;
        if (payload_count >= PAYLOAD_BYTES) hunt_phase = PH_CHECK;
      end
      default: begin
        xor_check = xor_check ^ b;
        w.frame_valid   = (xor_check == CHECK_OK);
        w.frame_payload = '0;
        // bytes above the payload length stay zero
        for (i = 0; i < PAYLOAD_BYTES; i++) w.frame_payload[8*i +: 8] = payload_bytes[i];
        expected_frames.push_back(w);
        hunt_phase    = PH_HUNT0;
        payload_count = '0;
        xor_check     = CHECK_INIT;
      end
    endcase
  endtask

  // offer one byte on in_, optionally after a random gap, and hold it until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    deframe_byte(b);
    bytes_sent++;
  endtask

  // two sync words, the payload, then a check word that is right unless corrupted
  task automatic send_frame(input logic [BYTE_W-1:0] sync, input logic [PAYLOAD_W-1:0] data,
                            input bit corrupt);
    logic [BYTE_W-1:0] chk;
    int                i;
    chk = CHECK_INIT;
    send_byte(sync);
    send_byte(sync);
    for (i = 0; i < PAYLOAD_BYTES; i++) begin
      send_byte(data[8*i +: 8]);
      chk = chk ^ data[8*i +: 8];
    end
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  // stop offering, let every expected word drain, then idle for SETTLE_CYCLES
  task automatic quiesce();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // the sync register is only touched once in_ has stopped and every expected word has drained
  task automatic write_sync(input logic [BYTE_W-1:0] v);
    quiesce();
    cfg_valid     <= 1'b1;
    cfg_sync_byte <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid  <= 1'b0;
    sync_value = v;
    cfg_writes++;
  endtask

  function automatic logic [PAYLOAD_W-1:0] random_payload();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] b;
    b = 8'($urandom);
    if (b == v) b = ~v;
    return b;
  endfunction

  // frame with the sync value still at its reset setting of zero
  task automatic test_reset_sync();
    send_frame(8'h00, 64'h01FE_7F80_FF00_FF00, 1'b0);
  endtask

  // broken hunt, third sync word as first payload byte, sync inside payload, bad check
  task automatic test_directed_cases();
    write_sync(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h12);
    send_frame(8'hFF, 64'h0000_FF00_0000_00FF, 1'b1);
  endtask

  // new sync value written while a frame is half collected must not disturb it
  task automatic test_sync_change_mid_frame();
    write_sync(8'h3C);
    send_byte(8'h3C);
    send_byte(8'h3C);
    send_byte(8'h3C);
    send_byte(8'hA1);
    send_byte(8'h00);
    write_sync(8'hC3);
    send_byte(8'hC3);
    send_byte(8'h3C);
    send_byte(8'h7E);
    send_byte(8'h81);
    send_byte(8'hC3);
    send_byte(8'h5D);
    send_frame(8'hC3, random_payload(), 1'b0);
  endtask

  // mostly well-formed frames with random content, mixed with noise, broken
  // hunts and truncated frames, over several sync settings and idle mixes
  task automatic test_random_traffic();
    logic [BYTE_W-1:0] settings [5];
    int unsigned       start;
    int unsigned       pick;
    int unsigned       n;
    int                p;
    settings[0] = 8'h00;
    settings[1] = 8'hFF;
    settings[2] = 8'($urandom);
    settings[3] = 8'($urandom);
    settings[4] = 8'h5A;
    for (p = 0; p < 5; p++) begin
      write_sync(settings[p]);
      tx_idle = (p != 1) && (p != 3);
      rx_idle = (p != 1) && (p != 2);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_WORDS) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          send_frame(sync_value, random_payload(), $urandom_range(0, 2) == 0);
        end else if (pick == 7) begin
          send_byte(($urandom_range(0, 3) == 0) ? sync_value : 8'($urandom));
        end else if (pick == 8) begin
          send_byte(sync_value);
          send_byte(other_than(sync_value));
        end else begin
          // frame cut short, the next frame's words land in its payload
          send_byte(sync_value);
          send_byte(sync_value);
          n = $urandom_range(0, PAYLOAD_BYTES - 1);
          repeat (n) send_byte(8'($urandom));
        end
      end
    end
  endtask

  // receiver holds off long enough for the result register to fill and stall in_
  task automatic test_output_backpressure();
    quiesce();
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_len = LONG_HOLD;
    repeat (6) send_frame(sync_value, random_payload(), $urandom_range(0, 1) == 0);
    quiesce();
  endtask

  // sender stops until every frame word is out, once between frames, once mid-frame
  task automatic test_sender_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (3) send_frame(sync_value, random_payload(), 1'b0);
    quiesce();
    send_byte(sync_value);
    send_byte(sync_value);
    repeat (4) send_byte(8'($urandom));
    quiesce();
    repeat (PAYLOAD_BYTES - 4 + 1) send_byte(8'($urandom));
    send_frame(sync_value, random_payload(), 1'b1);
  endtask

  // receiver side: random stall per word, or one long hold when asked
  initial begin : receiver
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_len != 0) begin
        stall    = hold_len;
        hold_len = 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // compare every taken frame word with the oldest prediction
  always @(posedge clk) begin : check_frames
    frame_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected word, frame_valid %0b payload %h", $time, out_frame_valid,
                 out_frame_payload);
        error_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_frame_valid !== want.frame_valid) begin
          $display("%0t: frame_valid expected %0b actual %0b", $time, want.frame_valid,
                   out_frame_valid);
          error_count++;
        end
        if (out_frame_payload !== want.frame_payload) begin
          $display("%0t: frame_payload expected %h actual %h", $time, want.frame_payload,
                   out_frame_payload);
          error_count++;
        end
        frames_checked++;
        if (want.frame_valid) good_frames++;
      end
    end
  end

  // give up when no channel has moved a word for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d words still expected", $time,
                 STALL_LIMIT, expected_frames.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_rx_byte    = '0;
    cfg_valid     = 1'b0;
    cfg_sync_byte = '0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    hold_len      = 0;
    hunt_phase    = PH_HUNT0;
    payload_count = '0;
    xor_check     = CHECK_INIT;
    sync_value    = '0;
    for (int i = 0; i < 8; i++) payload_bytes[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_sync();
    test_directed_cases();
    test_sync_change_mid_frame();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    quiesce();

    $display("%0d bytes sent, %0d frames checked (%0d with a good check)", bytes_sent,
             frames_checked, good_frames);
    $display("%0d sync settings written, long output hold and mid-stream pauses included",
             cfg_writes);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sync_xor_frame_receiver.f
rtl/sfr_pkg.sv
rtl/sfr_deframer.sv
rtl/sfr_out_stage.sv
rtl/sync_xor_frame_receiver.sv
sim/sync_xor_frame_receiver_tb.sv
